// ----- hw/rtl/keyed_token_bucket_limiter_macros.svh -----
// ----------------------------------------------------------------------------
// Keyed token bucket limiter assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_TOKEN_BUCKET_LIMITER_MACROS_SVH
`define KEYED_TOKEN_BUCKET_LIMITER_MACROS_SVH

// same-cycle implication
`define KTBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KTBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ktbl_pkg.sv -----
// ----------------------------------------------------------------------------
// ktbl_pkg
// Types and constants of the keyed token bucket limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ktbl_pkg;

    localparam int LIMIT_W  = 16;
    localparam int TIME_W   = 32;
    localparam int EXPIRY_W = 20;
    localparam int QUOT_W   = 16;
    localparam int QCNT_W   = 4;
    localparam int KEY_W    = 8;
    localparam int OP_W     = 2;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int PROD_W   = TIME_W + LIMIT_W;
    localparam int CAP_W    = 2 * LIMIT_W;

    localparam logic [OP_W-1:0] OP_ALLOW   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEANUP = 2'd2;

    localparam logic [1:0] REG_LIMIT  = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_EXPIRY = 2'd2;

    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 16'd10;
    localparam logic [LIMIT_W-1:0]  WINDOW_RST = 16'd60;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RST = 20'd3600;

    typedef struct packed {
        logic [LIMIT_W-1:0] tokens;
        logic [TIME_W-1:0]  last_time;
    } entry_t;

endpackage

// ----- hw/rtl/keyed_token_bucket_limiter.sv -----
// ----------------------------------------------------------------------------
// keyed_token_bucket_limiter
// Per-key token bucket table: allow, reset key and cleanup sweep.
// ----------------------------------------------------------------------------
// Allow: S_RD, S_ELAP, S_MUL, S_CMP, the 16-step refill divider S_DIV, S_SUM and S_FIN;
// a new entry or a refill that reaches the limit skips S_DIV and S_SUM.
// Reset key, unused operations and out-of-range keys go straight to S_FIN.
// Cleanup: reads each of min(NUM_KEYS,256) entries (S_SW_RD), then checks it (S_SW_CHK), then S_FIN.
// One item at a time; the next item is taken once the result is registered.
// Reset clears entry valid bits at once; no clearing pass, items taken at once.
`timescale 1ns / 1ps
`include "keyed_token_bucket_limiter_macros.svh"

module keyed_token_bucket_limiter
    import ktbl_pkg::*;
#(
    parameter int NUM_KEYS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [KEY_W-1:0]    key_index,
    input  logic [TIME_W-1:0]   now_seconds,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                allowed
);

    localparam int DEPTH = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_ELAP,
        S_MUL,
        S_CMP,
        S_DIV,
        S_SUM,
        S_FIN,
        S_SW_RD,
        S_SW_CHK
    } state_t;

    // configuration
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  window_reg;
    logic [EXPIRY_W-1:0] expiry_reg;
    logic [LIMIT_W-1:0]  win_eff;
    logic                cfg_wr;

    // control
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                allowed_reg, allowed_next;
    logic [DEPTH-1:0]    valid_reg, valid_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]       sweep_reg, sweep_next;

    // payload
    logic [OP_W-1:0]     op_reg, op_next;
    logic [AW-1:0]       key_reg, key_next;
    logic                key_ok_reg, key_ok_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [LIMIT_W-1:0]  tokens_reg, tokens_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [QUOT_W-1:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0]   shift_reg, shift_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [LIMIT_W-1:0]  level_reg, level_next;

    // memory
    entry_t              bucket_mem [DEPTH];
    entry_t              rd_data_reg;
    entry_t              mem_wdata;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;

    logic                fin_go;
    logic [QUOT_W:0]     trial;
    logic [QUOT_W:0]     level_sum;
    logic [TIME_W-1:0]   sweep_age;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign win_eff  = (window_reg == '0) ? LIMIT_W'(1) : window_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign allowed   = allowed_reg;
    assign fin_go    = !out_valid_reg || out_ready;
    assign mem_raddr = (state_reg == S_SW_RD) ? sweep_reg : key_reg;
    assign trial     = {rem_reg, shift_reg[QUOT_W-1]};
    assign level_sum = {1'b0, tokens_reg} + {1'b0, quot_reg};
    assign sweep_age = (now_reg > rd_data_reg.last_time)
                       ? (now_reg - rd_data_reg.last_time) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RST;
            window_reg <= WINDOW_RST;
            expiry_reg <= EXPIRY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_LIMIT:  limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_WINDOW: window_reg <= pwdata[LIMIT_W-1:0];
                REG_EXPIRY: expiry_reg <= pwdata[EXPIRY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LIMIT:  prdata = PDATA_W'(limit_reg);
            REG_WINDOW: prdata = PDATA_W'(window_reg);
            REG_EXPIRY: prdata = PDATA_W'(expiry_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bucket_mem[key_reg] <= mem_wdata;
        end
        rd_data_reg <= bucket_mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        allowed_next   = allowed_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        sweep_next     = sweep_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        key_ok_next    = key_ok_reg;
        now_next       = now_reg;
        tokens_next    = tokens_reg;
        elapsed_next   = elapsed_reg;
        prod_next      = prod_reg;
        cap_next       = cap_reg;
        rem_next       = rem_reg;
        shift_next     = shift_reg;
        quot_next      = quot_reg;
        level_next     = level_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = operation;
                    key_next    = key_index[AW-1:0];
                    key_ok_next = (32'(key_index) < 32'(NUM_KEYS));
                    now_next    = now_seconds;
                    priority if (operation == OP_ALLOW
                                 && (32'(key_index) < 32'(NUM_KEYS)))
                        state_next = S_RD;
                    else if (operation == OP_CLEANUP)
                    begin
                        sweep_next = '0;
                        state_next = S_SW_RD;
                    end
                    else
                        state_next = S_FIN;
                end
            end
            S_RD:
            begin
                state_next = S_ELAP;
            end
            S_ELAP:
            begin
                tokens_next  = rd_data_reg.tokens;
                elapsed_next = (now_reg > rd_data_reg.last_time)
                               ? (now_reg - rd_data_reg.last_time) : '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(elapsed_reg) * PROD_W'(limit_reg);
                cap_next   = CAP_W'(limit_reg) * CAP_W'(win_eff);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (!valid_reg[key_reg])
                begin
                    level_next = limit_reg;
                    state_next = S_FIN;
                end
                else if (prod_reg >= PROD_W'(cap_reg))
                begin
                    level_next = limit_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    rem_next   = prod_reg[2*QUOT_W-1:QUOT_W];
                    shift_next = prod_reg[QUOT_W-1:0];
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (trial >= {1'b0, win_eff})
                begin
                    rem_next  = QUOT_W'(trial - {1'b0, win_eff});
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[QUOT_W-1:0];
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                shift_next = {shift_reg[QUOT_W-2:0], 1'b0};
                cnt_next   = cnt_reg + QCNT_W'(1);
                if (cnt_reg == QCNT_W'(QUOT_W - 1))
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                level_next = (level_sum > {1'b0, limit_reg})
                             ? limit_reg : level_sum[LIMIT_W-1:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    allowed_next   = 1'b0;
                    priority if (op_reg == OP_ALLOW && key_ok_reg)
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.tokens    = (level_reg != '0)
                                              ? (level_reg - LIMIT_W'(1)) : '0;
                        mem_wdata.last_time = now_reg;
                        valid_next[key_reg] = 1'b1;
                        allowed_next        = (level_reg != '0);
                    end
                    else if (op_reg == OP_RESET && key_ok_reg)
                        valid_next[key_reg] = 1'b0;
                    else
                    begin
                    end
                    state_next = S_IDLE;
                end
            end
            S_SW_RD:
            begin
                state_next = S_SW_CHK;
            end
            S_SW_CHK:
            begin
                if (valid_reg[sweep_reg] && (sweep_age > TIME_W'(expiry_reg)))
                    valid_next[sweep_reg] = 1'b0;
                if (sweep_reg == AW'(DEPTH - 1))
                    state_next = S_FIN;
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                    state_next = S_SW_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            allowed_reg   <= 1'b0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            sweep_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            allowed_reg   <= allowed_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            sweep_reg     <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        key_ok_reg  <= key_ok_next;
        now_reg     <= now_next;
        tokens_reg  <= tokens_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        cap_reg     <= cap_next;
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        quot_reg    <= quot_next;
        level_reg   <= level_next;
    end

    `KTBL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "accepted item did not block input")
    `KTBL_ASSERT_SAME(a_div_remainder, state_reg == S_DIV, rem_reg < win_eff,
        "divider remainder not below window")
    `KTBL_ASSERT_SAME(a_grant_writes_entry,
        state_reg == S_FIN && fin_go && allowed_next, mem_we,
        "granted item without entry write")

endmodule
